/* rtl/core/des_key_schedule_defines.svh */
// assertion macros for the key schedule checker
`ifndef DES_KEY_SCHEDULE_DEFINES_SVH
`define DES_KEY_SCHEDULE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DKS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key schedule check failed");

// next-cycle implication, sampled on clk, off during reset
`define DKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key schedule check failed");

`endif

/* rtl/core/dks_pkg.sv */
`default_nettype none

package dks_pkg;

    localparam int DKS_KEY_W       = 64;
    localparam int DKS_HALF_W      = 28;
    localparam int DKS_CD_W        = 56;
    localparam int DKS_SUBKEY_W    = 48;
    localparam int DKS_ROUNDS      = 16;
    localparam int DKS_ROUND_W     = 4;
    localparam int DKS_QUEUE_DEPTH = 2;

    typedef logic [DKS_KEY_W-1:0]    key_t;
    typedef logic [DKS_HALF_W-1:0]   half_t;
    typedef logic [DKS_SUBKEY_W-1:0] subkey_t;
    typedef logic [DKS_ROUND_W-1:0]  round_t;

    typedef struct packed {
        half_t c;
        half_t d;
    } cd_t;

    localparam round_t LAST_ROUND = round_t'(DKS_ROUNDS - 1);

    // bit k set where round k rotates by two places
    localparam logic [DKS_ROUNDS-1:0] SHIFT_TWO_MASK = 16'h7EFC;

    localparam byte unsigned PC1_TAB [DKS_CD_W] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };

    localparam byte unsigned PC2_TAB [DKS_SUBKEY_W] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // bit 1 of the standard is the msb of every vector
    function automatic cd_t dks_pc1(key_t key);
        logic [DKS_CD_W-1:0] r;
        r = '0;
        for (int i = 0; i < DKS_CD_W; i++)
        begin
            r[DKS_CD_W-1-i] = key[DKS_KEY_W - int'(PC1_TAB[i])];
        end
        return cd_t'(r);
    endfunction

    function automatic subkey_t dks_pc2(cd_t cd);
        logic [DKS_CD_W-1:0] src;
        subkey_t             r;
        src = cd;
        r   = '0;
        for (int i = 0; i < DKS_SUBKEY_W; i++)
        begin
            r[DKS_SUBKEY_W-1-i] = src[DKS_CD_W - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic half_t dks_rot(half_t h, logic two);
        half_t r;
        if (two)
        begin
            r = {h[DKS_HALF_W-3:0], h[DKS_HALF_W-1:DKS_HALF_W-2]};
        end
        else
        begin
            r = {h[DKS_HALF_W-2:0], h[DKS_HALF_W-1]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dks_if.sv */
`default_nettype none

interface dks_key_if import dks_pkg::*; ();
    logic valid;
    logic ready;
    key_t key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
    modport monitor (input valid, input key, input ready);
endinterface

interface dks_subkey_if import dks_pkg::*; ();
    logic    valid;
    logic    ready;
    subkey_t subkey;
    round_t  round_number;
    logic    last;

    modport source (output valid, output subkey, output round_number, output last,
                    input ready);
    modport sink (input valid, input subkey, input round_number, input last,
                  output ready);
    modport monitor (input valid, input subkey, input round_number, input last,
                     input ready);
endinterface

`default_nettype wire

/* rtl/core/dks_front.sv */
`default_nettype none

module dks_front import dks_pkg::*;
(
    dks_key_if.sink keys,
    output logic    push_valid,
    input  logic    push_ready,
    output cd_t     push_cd
);

    // pc-1 splits the key into the two halves; parity bits drop out
    assign push_cd    = dks_pc1(keys.key);
    assign push_valid = keys.valid;
    assign keys.ready = push_ready;

endmodule

`default_nettype wire

/* rtl/core/dks_queue.sv */
`default_nettype none

module dks_queue import dks_pkg::*;
#(
    parameter int DEPTH = DKS_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cd_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output cd_t  out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cd_t              entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dks_back.sv */
`default_nettype none

module dks_back import dks_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  cd_t           pop_cd,
    dks_subkey_if.source  subkeys
);

    logic    busy_reg;
    logic    busy_next;
    round_t  rnd_reg;
    round_t  rnd_next;
    cd_t     cd_reg;
    cd_t     cd_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    subkey_t subkey_reg;
    round_t  round_reg;
    logic    last_reg;

    logic    advance;
    logic    final_round;
    logic    load;
    cd_t     cd_rot;

    assign advance     = busy_reg && (!out_valid_reg || subkeys.ready);
    assign final_round = (rnd_reg == LAST_ROUND);
    assign pop_ready   = !busy_reg || (advance && final_round);
    assign load        = pop_valid && pop_ready;

    always_comb
    begin
        cd_rot.c = dks_rot(cd_reg.c, SHIFT_TWO_MASK[rnd_reg]);
        cd_rot.d = dks_rot(cd_reg.d, SHIFT_TWO_MASK[rnd_reg]);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        rnd_next       = rnd_reg;
        cd_next        = cd_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            rnd_next       = rnd_reg + 1'b1;
            cd_next        = cd_rot;
            out_valid_next = 1'b1;
            if (final_round)
            begin
                busy_next = 1'b0;
            end
        end
        else if (subkeys.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
            cd_next   = pop_cd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cd_reg <= cd_next;
        if (advance)
        begin
            subkey_reg <= dks_pc2(cd_rot);
            round_reg  <= rnd_reg;
            last_reg   <= final_round;
        end
    end

    assign subkeys.valid        = out_valid_reg;
    assign subkeys.subkey       = subkey_reg;
    assign subkeys.round_number = round_reg;
    assign subkeys.last         = last_reg;

endmodule

`default_nettype wire

/* rtl/core/des_key_schedule.sv */
// des key schedule
//
// keys: valid/ready channel carrying one 64-bit key per item (bit 1 of the
// standard is the msb; parity bits are ignored).
// subkeys: valid/ready channel giving sixteen items per key, one per round,
// each with the 48-bit pc-2 subkey, the round number 0 to 15 and a last flag
// on round 15.
// path: an accepted key is written into a queue entry, then loaded into the round
// unit's c/d register, and its first subkey is then registered in the output register.
// throughput: one subkey per cycle while keys wait and the receiver keeps ready
// high, set by the single rotate and pc-2 round unit feeding the output register.
// a small queue of pc-1 halves sits between input and round unit, so keys
// keep being accepted while a schedule is in progress or the output stalls.
// when the receiver holds ready low the output item stays put and the round
// unit waits; the queue fills and then keys.ready drops.
// reset clears the queue, the round unit and the output valid; no item is
// lost or repeated across a stall.
`default_nettype none

module des_key_schedule import dks_pkg::*;
#(
    parameter int QUEUE_DEPTH = DKS_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    dks_key_if.sink       keys,
    dks_subkey_if.source  subkeys
);

    logic push_valid;
    logic push_ready;
    cd_t  push_cd;
    logic pop_valid;
    logic pop_ready;
    cd_t  pop_cd;

    dks_front u_front (
        .keys       (keys),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cd    (push_cd)
    );

    dks_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_cd),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_cd)
    );

    dks_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cd    (pop_cd),
        .subkeys   (subkeys)
    );

endmodule

`default_nettype wire

/* rtl/core/dks_checker.sv */
`default_nettype none

`include "des_key_schedule_defines.svh"

module dks_checker import dks_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    valid,
    input  logic    ready,
    input  subkey_t subkey,
    input  round_t  round_number,
    input  logic    last
);

    round_t next_round;

    assign next_round = round_number + 1'b1;

    // a stalled item holds
    `DKS_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable({subkey, round_number, last}))

    // last flag marks exactly the final round
    `DKS_ASSERT_NOW(a_last_round, valid, last == (round_number == LAST_ROUND))

    // rounds of one key come out in order
    `DKS_ASSERT_NEXT(a_round_step, valid && ready && !last, !valid || round_number == $past(next_round))

endmodule

bind des_key_schedule dks_checker u_dks_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (subkeys.valid),
    .ready        (subkeys.ready),
    .subkey       (subkeys.subkey),
    .round_number (subkeys.round_number),
    .last         (subkeys.last)
);

`default_nettype wire
